// ===== rtl/gsm7_pkg.sv =====
// shared types, constants and character mapping for the septet packer
package gsm7_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned SEPTET_W  = 7;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned ACC_W     = 14;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W     = 2;
    localparam int unsigned FILL_W    = 3;

    localparam logic [BYTE_W-1:0] MAX_BYTES_RST = 8'd140;

    localparam logic [SEPTET_W-1:0] SEP_AT     = 7'h00;
    localparam logic [SEPTET_W-1:0] SEP_DOLLAR = 7'h02;
    localparam logic [SEPTET_W-1:0] SEP_SPACE  = 7'h20;

    localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5f;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7a;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
    } t_result;

    // up to two results produced by one character
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic              fire;
        logic [CHAR_W-1:0] chr;
        logic              last;
    } t_char_word;

    function automatic logic [SEPTET_W-1:0] to_septet(input logic [CHAR_W-1:0] c);
        logic [SEPTET_W-1:0] s;
        s = SEP_SPACE;
        if (c == CH_AT) begin
            s = SEP_AT;
        end else if (c == CH_DOLLAR) begin
            s = SEP_DOLLAR;
        end else if (c == CH_LF || c == CH_CR) begin
            s = c[SEPTET_W-1:0];
        end else if (c >= CH_SPACE && c <= CH_UNDER) begin
            s = c[SEPTET_W-1:0];
        end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            s = c[SEPTET_W-1:0];
        end
        return s;
    endfunction

endpackage

// ===== rtl/gsm7_pack_core.sv =====
// packing state and per-character septet merge, byte emit and overflow check
module gsm7_pack_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gsm7_pkg::t_char_word         i_word,
    input  logic [gsm7_pkg::BYTE_W-1:0]  i_max_bytes,
    output gsm7_pkg::t_push              o_push
);

    logic [gsm7_pkg::SEPTET_W-1:0] r_pend_bits, n_pend_bits;
    logic [gsm7_pkg::CNT_W-1:0]    r_pend_cnt,  n_pend_cnt;
    logic [gsm7_pkg::BYTE_W-1:0]   r_emitted,   n_emitted;
    logic                          r_aborted,   n_aborted;

    logic [gsm7_pkg::ACC_W-1:0]    w_acc;
    logic                          w_full;
    logic [gsm7_pkg::SEPTET_W-1:0] w_rem;
    logic [gsm7_pkg::CNT_W-1:0]    w_rem_cnt;
    logic [gsm7_pkg::BYTE_W-1:0]   w_em;
    gsm7_pkg::t_result             w_full_res;
    gsm7_pkg::t_result             w_tail_res;
    gsm7_pkg::t_result             w_err_res;

    assign w_acc = {{(gsm7_pkg::ACC_W-gsm7_pkg::SEPTET_W){1'b0}}, r_pend_bits}
                 | ({{(gsm7_pkg::ACC_W-gsm7_pkg::SEPTET_W){1'b0}},
                     gsm7_pkg::to_septet(i_word.chr)} << r_pend_cnt);
    assign w_full    = (r_pend_cnt != '0);
    assign w_rem     = w_full ? {1'b0, w_acc[gsm7_pkg::ACC_W-1:gsm7_pkg::BYTE_W]}
                              : w_acc[gsm7_pkg::SEPTET_W-1:0];
    assign w_rem_cnt = w_full ? r_pend_cnt - 3'd1 : 3'd7;
    assign w_em      = w_full ? r_emitted + 8'd1 : r_emitted;

    assign w_err_res.data = '0;
    assign w_err_res.last = 1'b1;
    assign w_err_res.ovf  = 1'b1;

    assign w_full_res.data = w_acc[gsm7_pkg::BYTE_W-1:0];
    assign w_full_res.last = i_word.last && (r_pend_cnt == 3'd1);
    assign w_full_res.ovf  = 1'b0;

    always_comb begin
        if (w_em >= i_max_bytes) begin
            w_tail_res = w_err_res;
        end else begin
            w_tail_res.data = {1'b0, w_rem};
            w_tail_res.last = 1'b1;
            w_tail_res.ovf  = 1'b0;
        end
    end

    always_comb begin
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_emitted   = r_emitted;
        n_aborted   = r_aborted;
        o_push.cnt  = 2'd0;
        o_push.res0 = w_full_res;
        o_push.res1 = w_tail_res;
        if (i_word.fire) begin
            if (r_aborted) begin
                if (i_word.last) begin
                    n_aborted = 1'b0;
                end
            end else if (w_full && (r_emitted >= i_max_bytes)) begin
                // capacity hit on the full byte
                o_push.cnt  = 2'd1;
                o_push.res0 = w_err_res;
                n_pend_bits = '0;
                n_pend_cnt  = '0;
                n_emitted   = '0;
                n_aborted   = !i_word.last;
            end else begin
                if (w_full) begin
                    o_push.cnt = 2'd1;
                end
                if (i_word.last) begin
                    if (w_rem_cnt != '0) begin
                        if (w_full) begin
                            o_push.cnt = 2'd2;
                        end else begin
                            o_push.cnt  = 2'd1;
                            o_push.res0 = w_tail_res;
                        end
                    end
                    n_pend_bits = '0;
                    n_pend_cnt  = '0;
                    n_emitted   = '0;
                end else begin
                    n_pend_bits = w_rem;
                    n_pend_cnt  = w_rem_cnt;
                    n_emitted   = w_em;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_emitted   <= '0;
            r_aborted   <= 1'b0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_emitted   <= n_emitted;
            r_aborted   <= n_aborted;
        end
    end

endmodule

// ===== rtl/gsm7_out_fifo.sv =====
// four-entry result queue, takes up to two results per cycle, gives one
module gsm7_out_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gsm7_pkg::t_push                 i_push,
    input  logic                            i_pop,
    output logic                            o_space2,
    output logic                            o_valid,
    output gsm7_pkg::t_result               o_head,
    output logic [gsm7_pkg::FILL_W-1:0]     o_fill
);

    gsm7_pkg::t_result                r_mem [gsm7_pkg::FIFO_DEPTH];
    logic [gsm7_pkg::PTR_W-1:0]       r_wr, n_wr;
    logic [gsm7_pkg::PTR_W-1:0]       r_rd, n_rd;
    logic [gsm7_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic [gsm7_pkg::PTR_W-1:0]       w_wr1;
    logic                             w_pop;

    assign o_valid  = (r_fill != '0);
    assign o_head   = r_mem[r_rd];
    assign o_space2 = (r_fill <= 3'd2);
    assign o_fill   = r_fill;
    assign w_pop    = i_pop && o_valid;
    assign w_wr1    = r_wr + 2'd1;

    always_comb begin
        n_wr   = r_wr + i_push.cnt;
        n_rd   = r_rd + {1'b0, w_pop};
        n_fill = r_fill + {1'b0, i_push.cnt} - {2'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

endmodule

// ===== rtl/gsm7_septet_packer_unit.sv =====
// top level of the gsm 7-bit septet packer: input register, packer, result queue
//
// channel   dir   payload                                   handshake
// s_axis    in    tdata[7:0] char_in, tlast last_char       tvalid/tready
// m_axis    out   tdata[7:0] packed_byte, tlast last_byte,  tvalid/tready
//                 tuser[0] overflow
// cfg       in    data[7:0] max_bytes                       i_cfg_valid/o_cfg_ready
//
// one character per cycle enters the input register when the input is not stalled, and is packed from there
// a character gives zero, one or two words; the result queue drains one word a cycle
// while m_axis_tready is high, so two-word characters (message ends) add an extra word of output
// input stalls only while the result queue holds more than two words
// synchronous active-low reset clears packing state and sets max_bytes to 140
module gsm7_septet_packer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] packed_byte
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // [0] overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic [gsm7_pkg::BYTE_W-1:0]  r_max_bytes;
    logic                         r_in_valid;
    logic [gsm7_pkg::CHAR_W-1:0]  r_in_char;
    logic                         r_in_last;
    logic                         w_space2;
    logic                         w_fire;
    gsm7_pkg::t_char_word         w_word;
    gsm7_pkg::t_push              w_push;
    gsm7_pkg::t_result            w_head;
    logic [gsm7_pkg::FILL_W-1:0]  w_fill;

    assign o_cfg_ready   = 1'b1;
    assign w_fire        = r_in_valid && w_space2;
    assign s_axis_tready = !r_in_valid || w_fire;

    assign w_word.fire = w_fire;
    assign w_word.chr  = r_in_char;
    assign w_word.last = r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= gsm7_pkg::MAX_BYTES_RST;
            r_in_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_bytes <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    gsm7_pack_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_word),
        .i_max_bytes (r_max_bytes),
        .o_push      (w_push)
    );

    gsm7_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (m_axis_tready),
        .o_space2 (w_space2),
        .o_valid  (m_axis_tvalid),
        .o_head   (w_head),
        .o_fill   (w_fill)
    );

    assign m_axis_tdata    = w_head.data;
    assign m_axis_tlast    = w_head.last;
    assign m_axis_tuser[0] = w_head.ovf;

    a_ovf_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("overflow word not a zero last word");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= 3'd4)
        else $error("result queue overfilled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in_char) && $stable(r_in_last))
        else $error("stalled input word lost");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |-> (w_push.cnt == 2'd0))
        else $error("result pushed without a character");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the septet packer: directed and random messages checked word by word
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 600000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_in
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] packed_byte
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;           // [0] overflow
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'h00;

    gsm7_septet_packer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // packer state as the testbench sees it
    logic [7:0] cap = gsm7_pkg::MAX_BYTES_RST;
    logic [6:0] held_bits = '0;
    logic [2:0] held_cnt = '0;
    logic [7:0] bytes_out = '0;
    logic       dropping = 1'b0;

    gsm7_pkg::t_result want_bytes[$];
    gsm7_pkg::t_result got_word;

    bit         idle_on = 1'b1;
    int         n_err = 0;
    int         n_chars = 0;
    int         n_msgs = 0;
    int         n_words = 0;
    int         n_ovf = 0;
    int         rx_hold = 0;
    int unsigned cycles = 0;

    function automatic logic [6:0] septet_of(input logic [7:0] c);
        if (c == gsm7_pkg::CH_AT)
            return gsm7_pkg::SEP_AT;
        if (c == gsm7_pkg::CH_DOLLAR)
            return gsm7_pkg::SEP_DOLLAR;
        if (c == gsm7_pkg::CH_LF || c == gsm7_pkg::CH_CR
            || (c >= gsm7_pkg::CH_SPACE && c <= gsm7_pkg::CH_UNDER)
            || (c >= gsm7_pkg::CH_LOW_A && c <= gsm7_pkg::CH_LOW_Z))
            return c[6:0];
        return gsm7_pkg::SEP_SPACE;
    endfunction

    function automatic void clear_packing();
        held_bits = '0;
        held_cnt  = '0;
        bytes_out = '0;
        dropping  = 1'b0;
    endfunction

    function automatic void push_word(input logic [7:0] d, input logic l, input logic o);
        gsm7_pkg::t_result r;
        r.data = d;
        r.last = l;
        r.ovf  = o;
        want_bytes.push_back(r);
    endfunction

    function automatic void pack_char(input logic [7:0] c, input logic last);
        logic [13:0] acc;
        logic [3:0]  nb;
        if (dropping) begin
            if (last)
                clear_packing();
            return;
        end
        acc = {7'b0, held_bits} | ({7'b0, septet_of(c)} << held_cnt);
        nb  = {1'b0, held_cnt} + 4'd7;
        if (nb >= 4'd8) begin
            if (bytes_out >= cap) begin
                push_word(8'h00, 1'b1, 1'b1);
                clear_packing();
                dropping = !last;
                return;
            end
            nb = nb - 4'd8;
            push_word(acc[7:0], last && nb == 0, 1'b0);
            bytes_out = bytes_out + 8'd1;
            acc = acc >> 8;
        end
        if (last) begin
            if (nb != 0) begin
                if (bytes_out >= cap)
                    push_word(8'h00, 1'b1, 1'b1);
                else
                    push_word(acc[7:0] & ((8'd1 << nb) - 8'd1), 1'b1, 1'b0);
            end
            clear_packing();
            return;
        end
        held_cnt  = nb[2:0];
        held_bits = acc[6:0] & ((7'd1 << held_cnt) - 7'd1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        n_err++;
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pack_char(c, last);
        n_chars++;
        if (last)
            n_msgs++;
    endtask

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(8'h20, 8'h7a));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_msg(input int len);
        for (int i = 0; i < len; i++)
            send_char(rand_char(), i == len - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (want_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [7:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap = v;
    endtask

    task automatic test_char_map();
        logic [7:0] chars[] = '{8'h00, 8'h0a, 8'h0d, 8'h1f, 8'h20, 8'h24, 8'h3f, 8'h40,
                                8'h5f, 8'h60, 8'h61, 8'h7a, 8'h7b, 8'h7f, 8'h80, 8'hff,
                                8'h55, 8'haa, 8'h0b, 8'h0c, 8'h0e, 8'h23, 8'h41, 8'h09};
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
        drain();
    endtask

    task automatic test_flush_lengths();
        for (int len = 1; len <= 16; len++)
            send_random_msg(len);
        drain();
    endtask

    task automatic test_capacity_limits();
        set_capacity(8'd1);
        send_random_msg(3);      // overflow on the last character
        send_random_msg(6);      // overflow mid message, rest dropped
        send_random_msg(2);      // overflow on the flushed byte
        send_random_msg(1);
        set_capacity(8'd0);
        send_random_msg(1);
        send_random_msg(4);
        set_capacity(8'd7);
        send_random_msg(8);      // exactly full, last word is a full byte
        set_capacity(8'd6);
        send_random_msg(8);
        set_capacity(8'd255);
        send_random_msg(291);    // fills the largest capacity
        send_random_msg(292);
        set_capacity(gsm7_pkg::MAX_BYTES_RST);
    endtask

    task automatic test_random_traffic(input int n_items);
        int start;
        int len;
        int pick;
        start = n_chars;
        while (n_chars - start < n_items) begin
            if ($urandom_range(0, 11) == 0) begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: set_capacity(8'd1);
                    1: set_capacity(8'd255);
                    2: set_capacity(8'($urandom_range(2, 12)));
                    default: set_capacity(8'($urandom_range(1, 255)));
                endcase
            end
            pick = $urandom_range(0, 19);
            if (pick < 15)
                len = $urandom_range(1, 24);
            else if (pick < 19)
                len = $urandom_range(25, 80);
            else
                len = $urandom_range(81, 300);
            send_random_msg(len);
        end
        drain();
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_hold <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_words++;
            if (m_axis_tuser[0])
                n_ovf++;
            if (want_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected word data %02h last %0b ovf %0b",
                                          m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
            end else begin
                got_word = want_bytes.pop_front();
                if (m_axis_tdata !== got_word.data || m_axis_tlast !== got_word.last
                    || m_axis_tuser[0] !== got_word.ovf)
                    report_mismatch($sformatf("got %02h/%0b/%0b want %02h/%0b/%0b",
                                              m_axis_tdata, m_axis_tlast, m_axis_tuser[0],
                                              got_word.data, got_word.last, got_word.ovf));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", want_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_char_map();
        test_flush_lengths();
        test_capacity_limits();
        test_random_traffic(450);
        idle_on = 1'b0;
        test_random_traffic(150);
        drain();
        if (want_bytes.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", want_bytes.size()));
        $display("sent %0d characters in %0d messages", n_chars, n_msgs);
        $display("checked %0d words, %0d of them overflow aborts", n_words, n_ovf);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
